/* rtl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define WAVP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wavp assertion failed");

// Checked at every edge, reset included.
`define WAVP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("wavp assertion failed");

`endif

/* rtl/wavp_pkg.sv */
`default_nettype none

package wavp_pkg;

  localparam logic [3:0]  HEADER_BYTES     = 4'd12;
  localparam logic [3:0]  CHUNK_HDR_BYTES  = 4'd8;
  localparam logic [3:0]  CHUNK_TAG_BYTES  = 4'd4;
  localparam logic [4:0]  FMT_MIN_LEN      = 5'd16;
  localparam logic [31:0] FMT_TAG          = 32'h20746D66;
  localparam logic [31:0] DEFAULT_RATE     = 32'd32000;
  localparam logic [15:0] DEFAULT_CHANNELS = 16'd2;
  localparam logic [15:0] DEFAULT_BITS     = 16'd32;
  localparam logic [15:0] NARROW_MAX_BITS  = 16'd16;
  localparam logic [15:0] MONO_CHANNELS    = 16'd1;

  typedef struct packed {
    logic       care;
    logic [7:0] value;
  } hdr_expect_t;

  typedef struct packed {
    logic        is_wav;
    logic [31:0] rate_hz;
    logic [15:0] channels;
    logic [15:0] sample_bits;
    logic        narrow_samples;
    logic        mono;
  } wavp_result_t;

  // "RIFF", four don't-care size bytes, "WAVE"
  function automatic hdr_expect_t header_expect(input logic [3:0] pos);
    hdr_expect_t e;
    e.care  = 1'b1;
    e.value = 8'h00;
    unique case (pos)
      4'd0:    e.value = 8'h52;
      4'd1:    e.value = 8'h49;
      4'd2:    e.value = 8'h46;
      4'd3:    e.value = 8'h46;
      4'd8:    e.value = 8'h57;
      4'd9:    e.value = 8'h41;
      4'd10:   e.value = 8'h56;
      4'd11:   e.value = 8'h45;
      default: e.care  = 1'b0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

/* rtl/wavp_if.sv */
`default_nettype none

interface wavp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wavp_out_if;
  logic        valid;
  logic        ready;
  logic        is_wav;
  logic [31:0] rate_hz;
  logic [15:0] channels;
  logic [15:0] sample_bits;
  logic        narrow_samples;
  logic        mono;

  modport source (output valid, output is_wav, output rate_hz, output channels,
                  output sample_bits, output narrow_samples, output mono,
                  input ready);
  modport sink   (input valid, input is_wav, input rate_hz, input channels,
                  input sample_bits, input narrow_samples, input mono,
                  output ready);
endinterface

`default_nettype wire

/* rtl/wav_header_format_parser.sv */
// RIFF/WAVE header parser. Feed the bytes of one buffer in file order, one item per
// cycle, with last_byte set on the final one; the block checks the RIFF....WAVE
// header, walks the chunks and keeps the format of the last complete 'fmt ' chunk.
// The item carrying last_byte yields one result item on the following cycle, with
// the parsed or default format (32000 Hz, 2 channels, 32 bits) and the at-most-16-bit and
// mono flags; the parser then starts over for the next buffer. Throughput is one
// byte per cycle, set by the update of the chunk byte counter (a 32-bit
// decrement and zero test). Input is held off while a result item waits unaccepted;
// a result taken in the same cycle frees the output register for the next one.
`default_nettype none

`include "assert_macros.svh"

module wav_header_format_parser
  import wavp_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  wavp_in_if.sink      in_i,
  wavp_out_if.source   out_o
);

  logic        hdr_phase;
  logic [3:0]  header_count_q, header_count_d;
  logic        header_match_q, header_match_d;
  logic [3:0]  chunk_hdr_cnt_q, chunk_hdr_cnt_d;
  logic [31:0] chunk_tag_q, chunk_tag_d;
  logic [31:0] chunk_len_q, chunk_len_d;
  logic [31:0] chunk_rem_q, chunk_rem_d;
  logic        pad_pending_q, pad_pending_d;
  logic        in_fmt_q, in_fmt_d;
  logic [4:0]  fmt_off_q, fmt_off_d;
  logic [31:0] pend_rate_q, pend_rate_d;
  logic [15:0] pend_ch_q, pend_ch_d;
  logic [15:0] pend_bits_q, pend_bits_d;
  logic [31:0] kept_rate_q, kept_rate_d;
  logic [15:0] kept_ch_q, kept_ch_d;
  logic [15:0] kept_bits_q, kept_bits_d;
  logic        out_valid_q, out_valid_d;
  wavp_result_t res_q, res_d;

  logic        in_acc;
  logic        end_acc;
  logic [7:0]  b;
  hdr_expect_t hexp;
  logic        wav;

  assign hdr_phase  = header_count_q < HEADER_BYTES;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc   = in_i.valid && in_i.ready;
  assign end_acc  = in_acc && in_i.last_byte;
  assign b        = in_i.data_byte;
  assign hexp     = header_expect(header_count_q);

  always_comb begin
    header_match_d  = header_match_q;
    header_count_d  = header_count_q;
    chunk_hdr_cnt_d = chunk_hdr_cnt_q;
    chunk_tag_d     = chunk_tag_q;
    chunk_len_d     = chunk_len_q;
    chunk_rem_d     = chunk_rem_q;
    pad_pending_d   = pad_pending_q;
    in_fmt_d        = in_fmt_q;
    fmt_off_d       = fmt_off_q;
    pend_rate_d     = pend_rate_q;
    pend_ch_d       = pend_ch_q;
    pend_bits_d     = pend_bits_q;
    kept_rate_d     = kept_rate_q;
    kept_ch_d       = kept_ch_q;
    kept_bits_d     = kept_bits_q;

    if (in_acc) begin
      if (hdr_phase) begin
        if (hexp.care && (b != hexp.value)) begin
          header_match_d = 1'b0;
        end
        header_count_d = header_count_q + 4'd1;
      end else if (header_match_q) begin
        if (pad_pending_q) begin
          pad_pending_d = 1'b0;
        end else if (chunk_hdr_cnt_q < CHUNK_HDR_BYTES) begin
          if (chunk_hdr_cnt_q < CHUNK_TAG_BYTES) begin
            chunk_tag_d = {b, chunk_tag_q[31:8]};
          end else begin
            chunk_len_d = {b, chunk_len_q[31:8]};
          end
          chunk_hdr_cnt_d = chunk_hdr_cnt_q + 4'd1;
          if (chunk_hdr_cnt_d == CHUNK_HDR_BYTES) begin
            in_fmt_d    = (chunk_tag_d == FMT_TAG) && (chunk_len_d >= 32'(FMT_MIN_LEN));
            fmt_off_d   = 5'd0;
            chunk_rem_d = chunk_len_d;
            // empty chunk: done with its header, never a usable fmt
            if (chunk_len_d == 32'd0) begin
              pad_pending_d   = 1'b0;
              in_fmt_d        = 1'b0;
              chunk_hdr_cnt_d = 4'd0;
            end
          end
        end else begin
          if (in_fmt_q && (fmt_off_q < FMT_MIN_LEN)) begin
            unique case (fmt_off_q[3:0])
              4'd2:    pend_ch_d[7:0]     = b;
              4'd3:    pend_ch_d[15:8]    = b;
              4'd4:    pend_rate_d[7:0]   = b;
              4'd5:    pend_rate_d[15:8]  = b;
              4'd6:    pend_rate_d[23:16] = b;
              4'd7:    pend_rate_d[31:24] = b;
              4'd14:   pend_bits_d[7:0]   = b;
              4'd15:   pend_bits_d[15:8]  = b;
              default: ;
            endcase
            fmt_off_d = fmt_off_q + 5'd1;
          end
          chunk_rem_d = chunk_rem_q - 32'd1;
          if (chunk_rem_d == 32'd0) begin
            if (in_fmt_q) begin
              kept_rate_d = pend_rate_d;
              kept_ch_d   = pend_ch_d;
              kept_bits_d = pend_bits_d;
            end
            pad_pending_d   = chunk_len_q[0];
            in_fmt_d        = 1'b0;
            chunk_hdr_cnt_d = 4'd0;
          end
        end
      end
    end

    wav = header_match_d && (header_count_d == HEADER_BYTES);
    res_d.is_wav          = wav;
    res_d.rate_hz         = wav ? kept_rate_d : DEFAULT_RATE;
    res_d.channels        = wav ? kept_ch_d : DEFAULT_CHANNELS;
    res_d.sample_bits     = wav ? kept_bits_d : DEFAULT_BITS;
    res_d.narrow_samples  = res_d.sample_bits <= NARROW_MAX_BITS;
    res_d.mono            = res_d.channels == MONO_CHANNELS;

    if (end_acc) begin
      header_count_d  = 4'd0;
      header_match_d  = 1'b1;
      chunk_hdr_cnt_d = 4'd0;
      chunk_tag_d     = 32'd0;
      chunk_len_d     = 32'd0;
      chunk_rem_d     = 32'd0;
      pad_pending_d   = 1'b0;
      in_fmt_d        = 1'b0;
      fmt_off_d       = 5'd0;
      pend_rate_d     = DEFAULT_RATE;
      pend_ch_d       = DEFAULT_CHANNELS;
      pend_bits_d     = DEFAULT_BITS;
      kept_rate_d     = DEFAULT_RATE;
      kept_ch_d       = DEFAULT_CHANNELS;
      kept_bits_d     = DEFAULT_BITS;
    end

    if (end_acc) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_count_q  <= 4'd0;
      header_match_q  <= 1'b1;
      chunk_hdr_cnt_q <= 4'd0;
      chunk_tag_q     <= 32'd0;
      chunk_len_q     <= 32'd0;
      chunk_rem_q     <= 32'd0;
      pad_pending_q   <= 1'b0;
      in_fmt_q        <= 1'b0;
      fmt_off_q       <= 5'd0;
      pend_rate_q     <= DEFAULT_RATE;
      pend_ch_q       <= DEFAULT_CHANNELS;
      pend_bits_q     <= DEFAULT_BITS;
      kept_rate_q     <= DEFAULT_RATE;
      kept_ch_q       <= DEFAULT_CHANNELS;
      kept_bits_q     <= DEFAULT_BITS;
      out_valid_q     <= 1'b0;
    end else begin
      header_count_q  <= header_count_d;
      header_match_q  <= header_match_d;
      chunk_hdr_cnt_q <= chunk_hdr_cnt_d;
      chunk_tag_q     <= chunk_tag_d;
      chunk_len_q     <= chunk_len_d;
      chunk_rem_q     <= chunk_rem_d;
      pad_pending_q   <= pad_pending_d;
      in_fmt_q        <= in_fmt_d;
      fmt_off_q       <= fmt_off_d;
      pend_rate_q     <= pend_rate_d;
      pend_ch_q       <= pend_ch_d;
      pend_bits_q     <= pend_bits_d;
      kept_rate_q     <= kept_rate_d;
      kept_ch_q       <= kept_ch_d;
      kept_bits_q     <= kept_bits_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_acc) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.is_wav          = res_q.is_wav;
  assign out_o.rate_hz         = res_q.rate_hz;
  assign out_o.channels        = res_q.channels;
  assign out_o.sample_bits     = res_q.sample_bits;
  assign out_o.narrow_samples  = res_q.narrow_samples;
  assign out_o.mono            = res_q.mono;

  `WAVP_ASSERT_ALWAYS(a_hdr_cnt_range, header_count_q <= HEADER_BYTES)
  `WAVP_ASSERT(a_restart_after_last, end_acc |=> header_count_q == 4'd0 && !in_fmt_q)
  `WAVP_ASSERT(a_result_from_last, $rose(out_valid_q) |-> $past(end_acc))
  `WAVP_ASSERT(a_no_chunks_on_mismatch, !header_match_q |-> chunk_hdr_cnt_q == 4'd0 && !in_fmt_q)

endmodule

`default_nettype wire

/* sim/wav_header_format_parser_tb.sv */
`timescale 1ns / 1ps

module wav_header_format_parser_tb
  import wavp_pkg::*;
;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam logic [31:0] DATA_TAG    = 32'h61746164;

  // Tracks the parser's walk over each buffer and holds the format it should report.
  class format_tracker;
    logic [3:0]   hdr_cnt;
    logic         hdr_ok;
    logic [3:0]   chunk_hdr_cnt;
    logic [31:0]  tag;
    logic [31:0]  len;
    logic [31:0]  remaining;
    logic         pad_due;
    logic         fmt_live;
    logic [4:0]   fmt_pos;
    logic [31:0]  p_rate;
    logic [15:0]  p_ch;
    logic [15:0]  p_bits;
    logic [31:0]  k_rate;
    logic [15:0]  k_ch;
    logic [15:0]  k_bits;
    wavp_result_t expected_formats[$];
    int           errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      hdr_cnt       = '0;
      hdr_ok        = 1'b1;
      chunk_hdr_cnt = '0;
      tag           = '0;
      len           = '0;
      remaining     = '0;
      pad_due       = 1'b0;
      fmt_live      = 1'b0;
      fmt_pos       = '0;
      p_rate        = DEFAULT_RATE;
      p_ch          = DEFAULT_CHANNELS;
      p_bits        = DEFAULT_BITS;
      k_rate        = DEFAULT_RATE;
      k_ch          = DEFAULT_CHANNELS;
      k_bits        = DEFAULT_BITS;
    endfunction

    function logic [7:0] magic_at(logic [3:0] pos);
      logic [95:0] magic;
      magic = {"RIFF", 32'h0, "WAVE"};
      return magic[95 - 8 * pos -: 8];
    endfunction

    function void close_chunk();
      if (fmt_live) begin
        k_rate = p_rate;
        k_ch   = p_ch;
        k_bits = p_bits;
      end
      pad_due       = len[0];
      fmt_live      = 1'b0;
      chunk_hdr_cnt = '0;
    endfunction

    function void walk_chunk(logic [7:0] b);
      if (pad_due) begin
        pad_due = 1'b0;
      end else if (chunk_hdr_cnt < CHUNK_HDR_BYTES) begin
        if (chunk_hdr_cnt < CHUNK_TAG_BYTES) tag = {b, tag[31:8]};
        else len = {b, len[31:8]};
        chunk_hdr_cnt++;
        if (chunk_hdr_cnt == CHUNK_HDR_BYTES) begin
          fmt_live  = (tag == FMT_TAG) && (len >= FMT_MIN_LEN);
          fmt_pos   = '0;
          remaining = len;
          if (remaining == 0) close_chunk();
        end
      end else begin
        if (fmt_live && fmt_pos < FMT_MIN_LEN) begin
          case (fmt_pos)
            5'd2: p_ch[7:0] = b;
            5'd3: p_ch[15:8] = b;
            5'd4, 5'd5, 5'd6, 5'd7: p_rate[8 * (fmt_pos - 4) +: 8] = b;
            5'd14: p_bits[7:0] = b;
            5'd15: p_bits[15:8] = b;
            default: ;
          endcase
          fmt_pos++;
        end
        remaining--;
        if (remaining == 0) close_chunk();
      end
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      wavp_result_t r;
      logic         wav;
      if (hdr_cnt < HEADER_BYTES) begin
        if ((hdr_cnt < 4 || hdr_cnt > 7) && b != magic_at(hdr_cnt)) hdr_ok = 1'b0;
        hdr_cnt++;
      end else if (hdr_ok) begin
        walk_chunk(b);
      end
      if (last) begin
        wav               = hdr_ok && (hdr_cnt == HEADER_BYTES);
        r.is_wav          = wav;
        r.rate_hz         = wav ? k_rate : DEFAULT_RATE;
        r.channels        = wav ? k_ch : DEFAULT_CHANNELS;
        r.sample_bits     = wav ? k_bits : DEFAULT_BITS;
        r.narrow_samples  = r.sample_bits <= NARROW_MAX_BITS;
        r.mono            = r.channels == MONO_CHANNELS;
        expected_formats.push_back(r);
        restart();
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_format(wavp_result_t got);
      wavp_result_t want;
      if (expected_formats.size() == 0) begin
        report("result item with nothing expected");
      end else begin
        want = expected_formats.pop_front();
        if (got.is_wav !== want.is_wav)
          report($sformatf("is_wav %0d, want %0d", got.is_wav, want.is_wav));
        if (got.rate_hz !== want.rate_hz)
          report($sformatf("rate_hz %0d, want %0d", got.rate_hz, want.rate_hz));
        if (got.channels !== want.channels)
          report($sformatf("channels %0d, want %0d", got.channels, want.channels));
        if (got.sample_bits !== want.sample_bits)
          report($sformatf("sample_bits %0d, want %0d",
                           got.sample_bits, want.sample_bits));
        if (got.narrow_samples !== want.narrow_samples)
          report($sformatf("narrow_samples %0d, want %0d",
                           got.narrow_samples, want.narrow_samples));
        if (got.mono !== want.mono)
          report($sformatf("mono %0d, want %0d", got.mono, want.mono));
      end
    endtask

    function int pending();
      return expected_formats.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  wavp_in_if  in_if ();
  wavp_out_if out_if ();

  wav_header_format_parser DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  format_tracker tracker = new();
  logic [7:0]    buf_q[$];
  bit            idle_on;
  bit            hold_req;
  int unsigned   quiet;
  int            bytes_sent;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // acceptance monitor
  always @(posedge clk_i) begin
    wavp_result_t got;
    logic         moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        tracker.take_byte(in_if.data_byte, in_if.last_byte);
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        got.is_wav          = out_if.is_wav;
        got.rate_hz         = out_if.rate_hz;
        got.channels        = out_if.channels;
        got.sample_bits     = out_if.sample_bits;
        got.narrow_samples  = out_if.narrow_samples;
        got.mono            = out_if.mono;
        tracker.check_format(got);
        moved = 1'b1;
      end
    end
    if (moved) quiet = 0;
    else quiet++;
  end

  initial begin
    quiet = 0;
    while (quiet < QUIET_LIMIT) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  // result receiver
  initial begin
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) buf_q.push_back(v[8 * i +: 8]);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) buf_q.push_back(s[i]);
  endfunction

  function automatic void start_wav();
    buf_q.delete();
    put_text("RIFF");
    put_le($urandom, 4);
    put_text("WAVE");
  endfunction

  function automatic void put_chunk(logic [31:0] tag, logic [31:0] len, int body, bit pad);
    put_le(tag, 4);
    put_le(len, 4);
    repeat (body) buf_q.push_back(8'($urandom));
    if (pad && len[0] && body == len) buf_q.push_back(8'($urandom));
  endfunction

  function automatic void put_fmt(logic [31:0] len, int body, logic [15:0] ch,
                                  logic [31:0] rate, logic [15:0] bits, bit pad);
    logic [127:0] fields;
    fields = {bits, 16'($urandom), 32'($urandom), rate, ch, 16'($urandom)};
    put_le(FMT_TAG, 4);
    put_le(len, 4);
    for (int i = 0; i < body; i++)
      buf_q.push_back(i < 16 ? fields[8 * i +: 8] : 8'($urandom));
    if (pad && len[0] && body == len) buf_q.push_back(8'($urandom));
  endfunction

  function automatic logic [15:0] rand_ch();
    case ($urandom_range(0, 3))
      0: return 16'd1;
      1: return 16'd2;
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(0, 3))
      0: return 32'd44100;
      1: return 32'd48000;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_bits();
    case ($urandom_range(0, 5))
      0: return 16'd8;
      1: return 16'd16;
      2: return 16'd17;
      3: return 16'd24;
      4: return 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_tag();
    case ($urandom_range(0, 3))
      0: return FMT_TAG ^ (32'h1 << $urandom_range(0, 31));
      1: return DATA_TAG;
      2: return FMT_TAG;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic send_buffer(input int keep);
    for (int i = 0; i < keep; i++) send_byte(buf_q[i], i == keep - 1);
    bytes_sent += keep;
  endtask

  task automatic send_noise(input int n);
    buf_q.delete();
    repeat (n) buf_q.push_back(8'($urandom));
    if ($urandom_range(0, 1)) buf_q[0] = "R";
    send_buffer(n);
  endtask

  task automatic send_random_wav();
    int unsigned flen;
    int unsigned clen;
    start_wav();
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 7))
        0, 1, 2: begin
          case ($urandom_range(0, 3))
            0: flen = $urandom_range(14, 15);
            1: flen = $urandom_range(17, 28);
            default: flen = 16;
          endcase
          put_fmt(flen, flen, rand_ch(), rand_rate(), rand_bits(), $urandom_range(0, 7) != 0);
        end
        3: begin
          clen = $urandom_range(0, 9);
          put_chunk(rand_tag(), clen, clen, 1'b1);
        end
        4: put_chunk(rand_tag(), 32'd0, 0, 1'b1);
        5: put_fmt($urandom | 32'h100, $urandom_range(0, 20), rand_ch(), rand_rate(),
                   rand_bits(), 1'b1);
        6: begin
          clen = $urandom_range(1, 12);
          put_chunk(DATA_TAG, clen, clen, $urandom_range(0, 3) != 0);
        end
        default: repeat ($urandom_range(1, 4)) buf_q.push_back(8'($urandom));
      endcase
    end
    if ($urandom_range(0, 7) == 0) buf_q[$urandom_range(0, 11)] ^= 8'h1 << $urandom_range(0, 7);
    if ($urandom_range(0, 4) == 0) send_buffer($urandom_range(1, buf_q.size()));
    else send_buffer(buf_q.size());
  endtask

  task automatic send_random_buffer();
    case ($urandom_range(0, 19))
      0, 1, 2: send_noise($urandom_range(1, 20));
      3, 4, 5: begin
        start_wav();
        send_buffer($urandom_range(1, 12));
      end
      default: send_random_wav();
    endcase
  endtask

  initial begin
    int stop_at;
    bit pressed;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.last_byte = 1'b0;
    idle_on         = 1'b1;
    hold_req        = 1'b0;
    bytes_sent      = 0;
    pressed         = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single byte buffer
    buf_q.delete();
    buf_q.push_back(8'h00);
    send_buffer(1);
    // header mismatch, fmt afterwards is ignored
    buf_q.delete();
    put_text("RIFX");
    put_le(32'h0, 4);
    put_text("WAVE");
    put_fmt(16, 16, 16'd1, 32'd8000, 16'd8, 1'b1);
    send_buffer(buf_q.size());
    // header one byte short
    start_wav();
    send_buffer(11);
    // bare header
    start_wav();
    send_buffer(12);
    // mono 16-bit at max rate
    start_wav();
    put_fmt(16, 16, 16'd1, 32'hFFFF_FFFF, 16'd16, 1'b1);
    send_buffer(buf_q.size());
    // short fmt skipped, odd data chunk with its pad missing at the end
    start_wav();
    put_fmt(15, 15, 16'd1, 32'd8000, 16'd8, 1'b1);
    put_chunk(DATA_TAG, 3, 3, 1'b0);
    send_buffer(buf_q.size());
    // second fmt cut off by end of buffer
    start_wav();
    put_fmt(16, 16, 16'd3, 32'd44100, 16'd24, 1'b1);
    put_fmt(20, 10, 16'd1, 32'd8000, 16'd8, 1'b1);
    send_buffer(buf_q.size());
    // last complete fmt wins, zero-length and padded chunks between
    start_wav();
    put_fmt(16, 16, 16'd1, 32'd22050, 16'd8, 1'b1);
    put_chunk(DATA_TAG, 0, 0, 1'b1);
    put_chunk(32'hFFFF_FFFF, 5, 5, 1'b1);
    put_fmt(17, 17, 16'hFFFF, 32'd0, 16'hFFFF, 1'b1);
    send_buffer(buf_q.size());
    // all ones
    buf_q.delete();
    repeat (14) buf_q.push_back(8'hFF);
    send_buffer(14);
    // zero channels, 17 bits, trailing zero-length chunk
    start_wav();
    put_fmt(16, 16, 16'd0, 32'd96000, 16'd17, 1'b1);
    put_chunk(FMT_TAG, 0, 0, 1'b1);
    send_buffer(buf_q.size());

    while (bytes_sent < 500) begin
      idle_on = $urandom_range(0, 4) != 0;
      if (!pressed && bytes_sent >= 300) begin
        pressed  = 1'b1;
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (10) send_noise($urandom_range(1, 3));
      end else begin
        send_random_buffer();
      end
    end

    idle_on = 1'b0;
    stop_at = bytes_sent + 100;
    while (bytes_sent < stop_at) send_random_buffer();
    in_if.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
